FILE: src/pgsc_pkg.sv
package pgsc_pkg;

   // Grid geometry: coordinates are 5-bit, so the grid edge is fixed
   localparam int IDX_W      = 5;
   localparam int GRID_SIZE  = 1 << IDX_W;
   localparam int ADDR_W     = 3 * IDX_W;

   // Component and result widths
   localparam int COMP_W     = 16;
   localparam int NUM_COMP   = 6;
   localparam int WORD_W     = NUM_COMP * COMP_W;
   localparam int SUM_W      = 18;
   localparam int DIFF_W     = 20;
   localparam int CURL_W     = 24;
   localparam int SCALE_W    = 16;

   // Read schedule: seven grid points, three shifted copies per point
   localparam int PT_W       = 3;
   localparam int CP_W       = 2;
   localparam logic [PT_W-1:0] PT_CTR = 3'd0;
   localparam logic [PT_W-1:0] PT_JP  = 3'd1;
   localparam logic [PT_W-1:0] PT_JM  = 3'd2;
   localparam logic [PT_W-1:0] PT_KP  = 3'd3;
   localparam logic [PT_W-1:0] PT_KM  = 3'd4;
   localparam logic [PT_W-1:0] PT_IP  = 3'd5;
   localparam logic [PT_W-1:0] PT_IM  = 3'd6;
   localparam logic [PT_W-1:0] PT_LAST = PT_IM;

   localparam logic [CP_W-1:0] CP_Z    = 2'd0;
   localparam logic [CP_W-1:0] CP_X    = 2'd1;
   localparam logic [CP_W-1:0] CP_Y    = 2'd2;

   // Request kinds
   localparam logic REQ_LOAD  = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   // Register indexes
   localparam int CSR_ADDR_W = 2;
   localparam logic [CSR_ADDR_W-1:0] CSR_SHIFT_X = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_SHIFT_Y = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_SHIFT_Z = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_SCALE   = 2'd3;

   // Control from the sequencer to the accumulator
   typedef struct packed {
      logic            clear;
      logic            vld;
      logic [PT_W-1:0] pt;
   } acc_ctl_type;

   typedef logic signed [SUM_W-1:0]  sum_type;
   typedef logic signed [DIFF_W-1:0] diff_type;

endpackage

FILE: src/pgsc_grid_mem.sv
module pgsc_grid_mem (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [pgsc_pkg::ADDR_W-1:0] wr_addr,
   input  logic [pgsc_pkg::WORD_W-1:0] wr_data,
   input  logic [pgsc_pkg::ADDR_W-1:0] rd_addr,
   output logic [pgsc_pkg::WORD_W-1:0] rd_data
);
   import pgsc_pkg::*;

   logic [WORD_W-1:0] mem [GRID_SIZE*GRID_SIZE*GRID_SIZE];
   logic [WORD_W-1:0] rd_data_ff;

   // One write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/pgsc_accum.sv
module pgsc_accum (
   input  logic                         clock,
   input  pgsc_pkg::acc_ctl_type        ctl,
   input  logic [pgsc_pkg::WORD_W-1:0] rd_data,
   output pgsc_pkg::sum_type            sums [pgsc_pkg::NUM_COMP],
   output pgsc_pkg::diff_type           diffs [3]
);
   import pgsc_pkg::*;

   logic signed [COMP_W-1:0] val [NUM_COMP];
   sum_type  sum_ff [NUM_COMP];
   sum_type  sum_in [NUM_COMP];
   diff_type diff_ff [3];
   diff_type diff_in [3];
   diff_type delta [3];
   diff_type px, py, pz;

   always_comb begin
      for (int c = 0; c < NUM_COMP; c++) begin
         val[c] = rd_data[c*COMP_W +: COMP_W];
      end
      px = DIFF_W'(val[0]);
      py = DIFF_W'(val[1]);
      pz = DIFF_W'(val[2]);
   end

   // Signed contribution of one position read to each curl difference
   always_comb begin
      delta[0] = '0;
      delta[1] = '0;
      delta[2] = '0;
      unique case (ctl.pt)
         PT_JP: begin delta[0] = pz;  delta[2] = -px; end
         PT_JM: begin delta[0] = -pz; delta[2] = px;  end
         PT_KP: begin delta[0] = -py; delta[1] = px;  end
         PT_KM: begin delta[0] = py;  delta[1] = -px; end
         PT_IP: begin delta[1] = -pz; delta[2] = py;  end
         PT_IM: begin delta[1] = pz;  delta[2] = -py; end
         default: begin end
      endcase
   end

   // Center sums and curl differences
   always_comb begin
      for (int c = 0; c < NUM_COMP; c++) begin
         if (ctl.clear) begin
            sum_in[c] = '0;
         end else if (ctl.vld && ctl.pt == PT_CTR) begin
            sum_in[c] = sum_ff[c] + SUM_W'(val[c]);
         end else begin
            sum_in[c] = sum_ff[c];
         end
      end
      for (int m = 0; m < 3; m++) begin
         if (ctl.clear) begin
            diff_in[m] = '0;
         end else if (ctl.vld) begin
            diff_in[m] = diff_ff[m] + delta[m];
         end else begin
            diff_in[m] = diff_ff[m];
         end
      end
   end

   always_ff @(posedge clock) begin
      sum_ff  <= sum_in;
      diff_ff <= diff_in;
   end

   assign sums  = sum_ff;
   assign diffs = diff_ff;

endmodule

FILE: src/periodic_grid_superpose_curl.sv
// Periodic grid superposition with scaled curl.
// req channel: tuser is the request kind (load or query); tdata carries the
// voxel coordinates and, for a load, the six base components. A load writes
// one voxel of the 32x32x32 base grid in the cycle it is transferred and
// produces no response; the block is ready again in the next cycle.
// A query reads 21 grid words (seven points times three shifted copies) from
// the single read port of the grid memory, one word a cycle, accumulating the
// superposed sums and curl differences; the three curl components then pass
// one at a time through a shared multiplier with round and saturate.
// A query occupies the block until its result moves to the output register,
// so no new request is taken while a query is in progress.
// The result sits in an output register: a new request is taken while it
// waits, and a following query stalls only at its final step until the held
// response is transferred.
// csr port: write shift_x, shift_y, shift_z, curl_scale while idle.
// Reset clears control state and csr registers; grid contents are undefined
// until written, and every voxel must be loaded before it is queried.
module periodic_grid_superpose_curl #(
   parameter int FRAC_BITS = 12
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // req_tdata: coord_i, coord_j, coord_k, pos_x, pos_y, pos_z,
   //            speed_x, speed_y, speed_z, zero fill
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [111:0]                         req_tdata,
   // req_tuser: req_type
   input  logic                                 req_tuser,
   // rsp_tdata: sum_pos_x, sum_pos_y, sum_pos_z, sum_speed_x, sum_speed_y,
   //            sum_speed_z, curl_out_x, curl_out_y, curl_out_z, zero fill
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [183:0]                         rsp_tdata,
   input  logic                                 csr_we,
   input  logic [pgsc_pkg::CSR_ADDR_W-1:0]      csr_addr,
   input  logic [pgsc_pkg::SCALE_W-1:0]         csr_wdata
);
   import pgsc_pkg::*;

   localparam int PROD_W = DIFF_W + SCALE_W;
   localparam int RND_W  = PROD_W + 1;
   localparam logic signed [RND_W-1:0] SAT_HI = RND_W'((64'sd1 <<< (CURL_W-1)) - 1);
   localparam logic signed [RND_W-1:0] SAT_LO = -RND_W'(64'sd1 <<< (CURL_W-1));
   localparam logic signed [RND_W-1:0] RND_HALF = RND_W'(64'sd1 <<< (FRAC_BITS-1));

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_READ  = 2'd1;
   localparam logic [1:0] ST_MUL   = 2'd2;
   localparam logic [1:0] ST_DONE  = 2'd3;

   logic [1:0]            state_ff, state_in;
   logic [PT_W-1:0]       pt_ff, pt_in;
   logic [CP_W-1:0]       cp_ff, cp_in;
   logic [1:0]            mcnt_ff, mcnt_in;
   logic [IDX_W-1:0]      ci_ff, cj_ff, ck_ff;
   logic [IDX_W-1:0]      shx_ff, shy_ff, shz_ff;
   logic signed [SCALE_W-1:0] scale_ff;
   logic                  rd_vld_ff, rd_vld_in;
   logic [PT_W-1:0]       rd_pt_ff;
   logic                  prod_vld_ff;
   logic [1:0]            prod_idx_ff;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [CURL_W-1:0] curl_ff [3];
   logic                  rsp_vld_ff, rsp_vld_in;
   logic [183:0]          rsp_data_ff;

   logic                  req_xfer, load_xfer, query_xfer, rsp_free;
   logic [IDX_W-1:0]      pi, pj, pk;
   logic [ADDR_W-1:0]     rd_addr;
   logic [WORD_W-1:0]     rd_data;
   acc_ctl_type           acc_ctl;
   sum_type               sums [NUM_COMP];
   diff_type              diffs [3];
   diff_type              d_sel;
   logic signed [RND_W-1:0] rnd, q;
   logic signed [CURL_W-1:0] sat;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign load_xfer  = req_xfer && req_tuser == REQ_LOAD;
   assign query_xfer = req_xfer && req_tuser == REQ_QUERY;
   assign rsp_free   = !rsp_vld_ff || rsp_tready;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         shx_ff   <= '0;
         shy_ff   <= '0;
         shz_ff   <= '0;
         scale_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_SHIFT_X: shx_ff   <= csr_wdata[IDX_W-1:0];
            CSR_SHIFT_Y: shy_ff   <= csr_wdata[IDX_W-1:0];
            CSR_SHIFT_Z: shz_ff   <= csr_wdata[IDX_W-1:0];
            CSR_SCALE:   scale_ff <= csr_wdata;
            default: begin end
         endcase
      end
   end

   // Query coordinates
   always_ff @(posedge clock) begin
      if (query_xfer) begin
         ci_ff <= req_tdata[IDX_W-1:0];
         cj_ff <= req_tdata[2*IDX_W-1:IDX_W];
         ck_ff <= req_tdata[3*IDX_W-1:2*IDX_W];
      end
   end

   // Grid point of the current read, wrapped by the 5-bit adds
   always_comb begin
      pi = ci_ff;
      pj = cj_ff;
      pk = ck_ff;
      unique case (pt_ff)
         PT_JP: pj = cj_ff + 1'b1;
         PT_JM: pj = cj_ff - 1'b1;
         PT_KP: pk = ck_ff + 1'b1;
         PT_KM: pk = ck_ff - 1'b1;
         PT_IP: pi = ci_ff + 1'b1;
         PT_IM: pi = ci_ff - 1'b1;
         default: begin end
      endcase
      unique case (cp_ff)
         CP_X:    rd_addr = {pk, pj, IDX_W'(pi + shx_ff)};
         CP_Y:    rd_addr = {pi, pk, IDX_W'(pj + shy_ff)};
         default: rd_addr = {pi, pj, IDX_W'(pk + shz_ff)};
      endcase
   end

   pgsc_grid_mem u_mem (
      .clock   (clock),
      .wr_en   (load_xfer),
      .wr_addr ({req_tdata[IDX_W-1:0], req_tdata[2*IDX_W-1:IDX_W],
                 req_tdata[3*IDX_W-1:2*IDX_W]}),
      .wr_data (req_tdata[3*IDX_W +: WORD_W]),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign acc_ctl.clear = query_xfer;
   assign acc_ctl.vld   = rd_vld_ff;
   assign acc_ctl.pt    = rd_pt_ff;

   pgsc_accum u_acc (
      .clock   (clock),
      .ctl     (acc_ctl),
      .rd_data (rd_data),
      .sums    (sums),
      .diffs   (diffs)
   );

   // Sequencer
   always_comb begin
      state_in   = state_ff;
      pt_in      = pt_ff;
      cp_in      = cp_ff;
      mcnt_in    = mcnt_ff;
      rd_vld_in  = 1'b0;
      rsp_vld_in = rsp_vld_ff && !rsp_tready;
      unique case (state_ff)
         ST_IDLE: begin
            if (query_xfer) begin
               state_in = ST_READ;
               pt_in    = PT_CTR;
               cp_in    = CP_Z;
            end
         end
         ST_READ: begin
            // one read issued per cycle; a final step issues none and drains the last
            rd_vld_in = (pt_ff <= PT_LAST);
            if (pt_ff > PT_LAST) begin
               state_in = ST_MUL;
               mcnt_in  = '0;
            end else if (cp_ff == CP_Y) begin
               cp_in = CP_Z;
               pt_in = pt_ff + 1'b1;
            end else begin
               cp_in = cp_ff + 1'b1;
            end
         end
         ST_MUL: begin
            mcnt_in = mcnt_ff + 1'b1;
            if (mcnt_ff == 2'd3) begin
               state_in = ST_DONE;
            end
         end
         default: begin
            if (rsp_free) begin
               rsp_vld_in = 1'b1;
               state_in   = ST_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         rd_vld_ff   <= 1'b0;
         prod_vld_ff <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         rd_vld_ff   <= rd_vld_in;
         prod_vld_ff <= (state_ff == ST_MUL) && (mcnt_ff != 2'd3);
         rsp_vld_ff  <= rsp_vld_in;
      end
      pt_ff    <= pt_in;
      cp_ff    <= cp_in;
      mcnt_ff  <= mcnt_in;
      rd_pt_ff <= pt_ff;
   end

   // Shared multiplier, then round half up and saturate
   always_comb begin
      unique case (mcnt_ff)
         2'd0:    d_sel = diffs[0];
         2'd1:    d_sel = diffs[1];
         default: d_sel = diffs[2];
      endcase
      prod_in = d_sel * scale_ff;
      rnd     = RND_W'(prod_ff) + RND_HALF;
      q       = rnd >>> FRAC_BITS;
      if (q > SAT_HI) begin
         sat = SAT_HI[CURL_W-1:0];
      end else if (q < SAT_LO) begin
         sat = SAT_LO[CURL_W-1:0];
      end else begin
         sat = q[CURL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      prod_ff     <= prod_in;
      prod_idx_ff <= mcnt_ff;
      if (prod_vld_ff) begin
         curl_ff[prod_idx_ff] <= sat;
      end
   end

   // Response register
   always_ff @(posedge clock) begin
      if (state_ff == ST_DONE && rsp_free) begin
         rsp_data_ff <= {4'b0, curl_ff[2], curl_ff[1], curl_ff[0],
                         sums[5], sums[4], sums[3], sums[2], sums[1], sums[0]};
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef ASSERT_OFF
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff == ST_DONE))
      else $error("response raised outside final step");
   a_read_tag: assert property (@(posedge clock) disable iff (reset)
      rd_vld_ff |-> rd_pt_ff <= PT_LAST)
      else $error("read tag beyond last grid point");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      query_xfer |=> state_ff == ST_READ && !rd_vld_ff)
      else $error("query did not start read phase");
`endif

endmodule
